// ===== rtl/content_index_table_defines.svh =====
// shared assertion macros for the content index table
`ifndef CONTENT_INDEX_TABLE_DEFINES_SVH
`define CONTENT_INDEX_TABLE_DEFINES_SVH

// implication checked on every clock outside reset
`define CIT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// implication whose consequent is checked in the next cycle
`define CIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== rtl/cit_pkg.sv =====
package cit_pkg;

    localparam int TableDepth = 64;

    localparam logic [1:0] CMD_REGISTER   = 2'd0;
    localparam logic [1:0] CMD_SEARCH     = 2'd1;
    localparam logic [1:0] CMD_LIST       = 2'd2;
    localparam logic [1:0] CMD_DEREGISTER = 2'd3;

    localparam logic [3:0] ST_ADDED    = 4'd0;
    localparam logic [3:0] ST_UPDATED  = 4'd1;
    localparam logic [3:0] ST_FOUND    = 4'd2;
    localparam logic [3:0] ST_NOTFOUND = 4'd3;
    localparam logic [3:0] ST_ENTRY    = 4'd4;
    localparam logic [3:0] ST_EMPTY    = 4'd5;
    localparam logic [3:0] ST_REMOVED  = 4'd6;
    localparam logic [3:0] ST_NONE     = 4'd7;
    localparam logic [3:0] ST_FULL     = 4'd8;

    localparam int EntryWidth = 176;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_REPLY,
        S_LIST
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture the command item, reset the scan
        logic rd_en;     // read entry at scan index
        logic step;      // advance scan index
        logic wr_en;     // write
        logic wr_new;    // write holds the command fields, else the compaction entry
        logic wr_tail;   // address is the entry count, else the match or write index
        logic keep;      // compaction: count a kept entry
        logic set_count; // commit compacted count
        logic inc_count;
        logic match_set; // latch the index of the entry just read as match
        logic emit;
        logic emit_entry;  // results carry the read entry
        logic emit_last;
        logic [3:0] status;
    } t_ctrl;

    // datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic scan_done;   // scan index has reached the entry count
        logic hit_content; // registered read matches the content key
        logic hit_peer;    // registered read matches the peer key
        logic empty;
        logic full;
        logic shrunk;      // compaction removed something
    } t_stat;

endpackage

// ===== rtl/content_index_table.sv =====
// one table read port and one write port
// throughput: one command at a time; busy drops in the cycle the final result shows
// each result is shown for one cycle with o_valid; the receiver cannot stall
// reset (synchronous, active low) empties the table; entry storage is not cleared
module content_index_table #(
    parameter int TABLE_DEPTH = cit_pkg::TableDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [63:0] i_peer_key,
    input  logic [63:0] i_content_key,
    input  logic [31:0] i_peer_ip,
    input  logic [15:0] i_svc_port,
    output logic        o_valid,
    output logic [3:0]  o_status,
    output logic [63:0] o_out_content,
    output logic [63:0] o_out_peer,
    output logic [31:0] o_out_ip,
    output logic [15:0] o_out_port,
    output logic        o_last
);
    cit_pkg::t_ctrl ctrl;
    cit_pkg::t_stat stat;

    cit_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    cit_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .o_stat        (stat),
        .i_cmd         (i_cmd),
        .i_peer_key    (i_peer_key),
        .i_content_key (i_content_key),
        .i_peer_ip     (i_peer_ip),
        .i_svc_port    (i_svc_port),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_out_content (o_out_content),
        .o_out_peer    (o_out_peer),
        .o_out_ip      (o_out_ip),
        .o_out_port    (o_out_port),
        .o_last        (o_last)
    );
endmodule

// ===== rtl/cit_ram.sv =====
module cit_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/cit_datapath.sv =====
module cit_datapath #(
    parameter int TABLE_DEPTH = cit_pkg::TableDepth
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cit_pkg::t_ctrl   i_ctrl,
    output cit_pkg::t_stat   o_stat,
    input  logic [1:0]       i_cmd,
    input  logic [63:0]      i_peer_key,
    input  logic [63:0]      i_content_key,
    input  logic [31:0]      i_peer_ip,
    input  logic [15:0]      i_svc_port,
    output logic             o_valid,
    output logic [3:0]       o_status,
    output logic [63:0]      o_out_content,
    output logic [63:0]      o_out_peer,
    output logic [31:0]      o_out_ip,
    output logic [15:0]      o_out_port,
    output logic             o_last
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

    logic [1:0]  r_cmd;
    logic [63:0] r_pkey, r_ckey;
    logic [31:0] r_ip;
    logic [15:0] r_port;
    logic [CW-1:0] r_count, r_scan, r_wptr, r_match;
    logic [cit_pkg::EntryWidth-1:0] rdata, wdata, r_hold;
    logic [AW-1:0] waddr;

    logic r_valid, r_last;
    logic [3:0] r_status;
    logic [63:0] r_oc, r_op;
    logic [31:0] r_oi;
    logic [15:0] r_oport;

    // write data and address selection
    always_comb begin
        wdata = i_ctrl.wr_new ? {r_ckey, r_pkey, r_ip, r_port} : r_hold;
        if (i_ctrl.wr_tail) begin
            waddr = r_count[AW-1:0];
        end else if (i_ctrl.wr_new) begin
            waddr = r_match[AW-1:0];
        end else begin
            waddr = r_wptr[AW-1:0];
        end
    end

    cit_ram #(.Width(cit_pkg::EntryWidth), .Depth(TABLE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.wr_en),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_ctrl.rd_en),
        .i_raddr (r_scan[AW-1:0]),
        .o_rdata (rdata)
    );

    // command capture, payload
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd  <= i_cmd;
            r_pkey <= i_peer_key;
            r_ckey <= i_content_key;
            r_ip   <= i_peer_ip;
            r_port <= i_svc_port;
        end
        if (i_ctrl.match_set) begin
            r_match <= r_scan - CW'(1);
        end
        r_hold <= rdata;
    end

    // scan, write pointer and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_scan  <= '0;
            r_wptr  <= '0;
        end else begin
            if (i_ctrl.load) begin
                r_scan <= '0;
                r_wptr <= '0;
            end else if (i_ctrl.step) begin
                r_scan <= r_scan + CW'(1);
            end
            if (i_ctrl.keep) begin
                r_wptr <= r_wptr + CW'(1);
            end
            if (i_ctrl.set_count) begin
                r_count <= r_wptr;
            end else if (i_ctrl.inc_count) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_comb begin
        o_stat.cmd         = r_cmd;
        o_stat.scan_done   = (r_scan == r_count);
        o_stat.hit_content = (rdata[175:112] == r_ckey);
        o_stat.hit_peer    = (rdata[111:48] == r_pkey);
        o_stat.empty       = (r_count == '0);
        o_stat.full        = (r_count == DepthC);
        o_stat.shrunk      = (r_wptr != r_count);
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctrl.emit;
        end
        if (i_ctrl.emit) begin
            r_status <= i_ctrl.status;
            r_last   <= i_ctrl.emit_last;
            if (i_ctrl.emit_entry) begin
                {r_oc, r_op, r_oi, r_oport} <= rdata;
            end else if (i_ctrl.wr_new) begin
                {r_oc, r_op, r_oi, r_oport} <= wdata;
            end else begin
                {r_oc, r_op, r_oi, r_oport} <= '0;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_out_content = r_oc;
    assign o_out_peer    = r_op;
    assign o_out_ip      = r_oi;
    assign o_out_port    = r_oport;
    assign o_last        = r_last;
endmodule

// ===== rtl/cit_ctrl.sv =====
module cit_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  cit_pkg::t_stat i_stat,
    output cit_pkg::t_ctrl o_ctrl
);
    cit_pkg::t_state r_state, n_state;
    logic r_pend, n_pend;   // a read issued last cycle is now on rdata

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cit_pkg::S_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_pend  = 1'b0;
        o_ctrl  = '0;
        busy    = (r_state != cit_pkg::S_IDLE);
        case (r_state)
            cit_pkg::S_IDLE: begin
                if (start) begin
                    o_ctrl.load = 1'b1;
                    n_state = cit_pkg::S_SCAN;
                end
            end
            cit_pkg::S_SCAN: begin
                // handle entry read last cycle
                if (r_pend) begin
                    case (i_stat.cmd)
                        cit_pkg::CMD_REGISTER, cit_pkg::CMD_SEARCH: begin
                            if (i_stat.hit_content) begin
                                o_ctrl.match_set = 1'b1;
                                if (i_stat.cmd == cit_pkg::CMD_SEARCH) begin
                                    o_ctrl.emit = 1'b1;
                                    o_ctrl.emit_entry = 1'b1;
                                    o_ctrl.emit_last = 1'b1;
                                    o_ctrl.status = cit_pkg::ST_FOUND;
                                    n_state = cit_pkg::S_IDLE;
                                end else begin
                                    n_state = cit_pkg::S_WRITE;
                                end
                            end
                        end
                        cit_pkg::CMD_LIST: begin
                            o_ctrl.emit = 1'b1;
                            o_ctrl.emit_entry = 1'b1;
                            o_ctrl.status = cit_pkg::ST_ENTRY;
                            o_ctrl.emit_last = i_stat.scan_done;
                            // final entry ends the command
                            if (i_stat.scan_done) begin
                                n_state = cit_pkg::S_IDLE;
                            end
                        end
                        default: begin
                            if (!i_stat.hit_peer) begin
                                o_ctrl.keep = 1'b1;
                                n_state = cit_pkg::S_LIST;
                            end
                        end
                    endcase
                end
                if (n_state == cit_pkg::S_SCAN) begin
                    if (i_stat.scan_done) begin
                        n_state = cit_pkg::S_REPLY;
                    end else begin
                        o_ctrl.rd_en = 1'b1;
                        o_ctrl.step  = 1'b1;
                        n_pend = 1'b1;
                    end
                end
                // kept entry: write it back at the write pointer next cycle
                if (n_state == cit_pkg::S_LIST) begin
                    o_ctrl.keep = 1'b0;
                end
            end
            cit_pkg::S_LIST: begin
                // compaction write of the held entry, then continue the scan or, once it is done, reply
                o_ctrl.wr_en = 1'b1;
                o_ctrl.keep  = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = cit_pkg::S_REPLY;
                end else begin
                    o_ctrl.rd_en = 1'b1;
                    o_ctrl.step  = 1'b1;
                    n_pend = 1'b1;
                    n_state = cit_pkg::S_SCAN;
                end
            end
            cit_pkg::S_WRITE: begin
                // update the matched entry in place
                o_ctrl.wr_en = 1'b1;
                o_ctrl.wr_new = 1'b1;
                o_ctrl.emit = 1'b1;
                o_ctrl.emit_last = 1'b1;
                o_ctrl.status = cit_pkg::ST_UPDATED;
                n_state = cit_pkg::S_IDLE;
            end
            cit_pkg::S_REPLY: begin
                o_ctrl.emit = 1'b1;
                o_ctrl.emit_last = 1'b1;
                n_state = cit_pkg::S_IDLE;
                case (i_stat.cmd)
                    cit_pkg::CMD_REGISTER: begin
                        if (i_stat.full) begin
                            o_ctrl.status = cit_pkg::ST_FULL;
                        end else begin
                            o_ctrl.wr_en = 1'b1;
                            o_ctrl.wr_new = 1'b1;
                            o_ctrl.wr_tail = 1'b1;
                            o_ctrl.inc_count = 1'b1;
                            o_ctrl.status = cit_pkg::ST_ADDED;
                        end
                    end
                    cit_pkg::CMD_SEARCH: o_ctrl.status = cit_pkg::ST_NOTFOUND;
                    cit_pkg::CMD_LIST: begin
                        // list results were given during the scan
                        o_ctrl.emit = i_stat.empty;
                        o_ctrl.status = cit_pkg::ST_EMPTY;
                    end
                    default: begin
                        o_ctrl.set_count = 1'b1;
                        o_ctrl.status = i_stat.shrunk ? cit_pkg::ST_REMOVED
                                                      : cit_pkg::ST_NONE;
                    end
                endcase
            end
            default: n_state = cit_pkg::S_IDLE;
        endcase
    end
endmodule

// ===== rtl/cit_checker.sv =====
`include "content_index_table_defines.svh"

module cit_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic [3:0] o_status,
    input logic       o_last
);
    logic single_status;

    // results other than list entries
    assign single_status = o_valid && (o_status != cit_pkg::ST_ENTRY);

    // an accepted item makes the block busy
    `CIT_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, start && !busy, busy)
    // every status but list entry ends the command
    `CIT_ASSERT_IMP(a_single_last, i_clk, i_rst_n, single_status, o_last)
    // the final result is shown while the block is free
    `CIT_ASSERT_IMP(a_free_at_last, i_clk, i_rst_n, o_valid && o_last, !busy)
    // no results while idle, other than in the cycle that the block goes idle
    `CIT_ASSERT_IMP(a_quiet_idle, i_clk, i_rst_n, !busy && !$past(busy), !o_valid)
endmodule

bind content_index_table cit_checker u_cit_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_status (o_status),
    .o_last   (o_last)
);

// ===== dv/content_index_table_tb.sv =====
module content_index_table_tb;

    localparam int Depth = cit_pkg::TableDepth;
    localparam int IdleLimit = 4000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] peer;
        logic [63:0] content;
        logic [31:0] ip;
        logic [15:0] port;
    } t_cmd_item;

    typedef struct packed {
        logic [3:0]  status;
        logic [63:0] content;
        logic [63:0] peer;
        logic [31:0] ip;
        logic [15:0] port;
        logic        last;
    } t_reply;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  cmd = '0;
    logic [63:0] peer_key = '0;
    logic [63:0] content_key = '0;
    logic [31:0] peer_ip = '0;
    logic [15:0] svc_port = '0;
    logic        valid;
    logic [3:0]  status;
    logic [63:0] out_content;
    logic [63:0] out_peer;
    logic [31:0] out_ip;
    logic [15:0] out_port;
    logic        last;

    t_cmd_item pending_cmds[$];
    t_reply    expected_replies[$];
    int        errors = 0;
    int        idle_cycles = 0;
    bit        timed_out = 1'b0;

    // shadow table
    logic [63:0] tbl_content[Depth];
    logic [63:0] tbl_peer[Depth];
    logic [31:0] tbl_ip[Depth];
    logic [15:0] tbl_port[Depth];
    int          tbl_count = 0;

    // small key pools so matches and peer removals happen often
    logic [63:0] content_pool[8];
    logic [63:0] peer_pool[4];

    content_index_table u_dut (
        .i_clk(clk), .i_rst_n(rst_n), .start(start), .busy(busy),
        .i_cmd(cmd), .i_peer_key(peer_key), .i_content_key(content_key),
        .i_peer_ip(peer_ip), .i_svc_port(svc_port),
        .o_valid(valid), .o_status(status), .o_out_content(out_content),
        .o_out_peer(out_peer), .o_out_ip(out_ip), .o_out_port(out_port),
        .o_last(last)
    );

    always #2 clk = ~clk;

    function automatic t_reply entry_reply(logic [3:0] st, int idx, logic lst);
        t_reply r;
        r = '{st, tbl_content[idx], tbl_peer[idx], tbl_ip[idx], tbl_port[idx], lst};
        return r;
    endfunction

    function automatic t_reply bare_reply(logic [3:0] st);
        t_reply r;
        r = '{st, 64'd0, 64'd0, 32'd0, 16'd0, 1'b1};
        return r;
    endfunction

    // update the shadow table and queue the replies one command causes
    task automatic predict_table(input t_cmd_item it);
        int hit;
        int w;
        hit = -1;
        for (int i = 0; i < tbl_count; i++)
            if (hit < 0 && tbl_content[i] == it.content) hit = i;
        case (it.cmd)
            cit_pkg::CMD_REGISTER: begin
                if (hit >= 0) begin
                    tbl_peer[hit] = it.peer;
                    tbl_ip[hit] = it.ip;
                    tbl_port[hit] = it.port;
                    expected_replies.push_back(entry_reply(cit_pkg::ST_UPDATED, hit, 1'b1));
                end else if (tbl_count < Depth) begin
                    tbl_content[tbl_count] = it.content;
                    tbl_peer[tbl_count] = it.peer;
                    tbl_ip[tbl_count] = it.ip;
                    tbl_port[tbl_count] = it.port;
                    expected_replies.push_back(
                        entry_reply(cit_pkg::ST_ADDED, tbl_count, 1'b1));
                    tbl_count++;
                end else begin
                    expected_replies.push_back(bare_reply(cit_pkg::ST_FULL));
                end
            end
            cit_pkg::CMD_SEARCH: begin
                if (hit >= 0)
                    expected_replies.push_back(entry_reply(cit_pkg::ST_FOUND, hit, 1'b1));
                else expected_replies.push_back(bare_reply(cit_pkg::ST_NOTFOUND));
            end
            cit_pkg::CMD_LIST: begin
                if (tbl_count == 0) expected_replies.push_back(bare_reply(cit_pkg::ST_EMPTY));
                for (int i = 0; i < tbl_count; i++)
                    expected_replies.push_back(
                        entry_reply(cit_pkg::ST_ENTRY, i, i == tbl_count - 1));
            end
            default: begin
                w = 0;
                for (int i = 0; i < tbl_count; i++) begin
                    if (tbl_peer[i] != it.peer) begin
                        tbl_content[w] = tbl_content[i];
                        tbl_peer[w] = tbl_peer[i];
                        tbl_ip[w] = tbl_ip[i];
                        tbl_port[w] = tbl_port[i];
                        w++;
                    end
                end
                if (w != tbl_count) begin
                    tbl_count = w;
                    expected_replies.push_back(bare_reply(cit_pkg::ST_REMOVED));
                end else begin
                    expected_replies.push_back(bare_reply(cit_pkg::ST_NONE));
                end
            end
        endcase
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic t_cmd_item random_cmd(logic [1:0] c);
        t_cmd_item it;
        it.cmd = c;
        it.peer = ($urandom_range(0, 9) == 0) ? rand64() : peer_pool[$urandom_range(0, 3)];
        it.content = ($urandom_range(0, 9) == 0) ? rand64()
                                                 : content_pool[$urandom_range(0, 7)];
        it.ip = $urandom();
        it.port = 16'($urandom());
        return it;
    endfunction

    // driver: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (start && !busy) begin
                predict_table({cmd, peer_key, content_key, peer_ip, svc_port});
            end
            if (start && busy) begin
                // hold the item until accepted
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                t_cmd_item it;
                it = pending_cmds.pop_front();
                {cmd, peer_key, content_key, peer_ip, svc_port} <= it;
                start <= 1'b1;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 8);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n && valid) begin
            if (expected_replies.size() == 0) begin
                $error("unexpected result, status %0d", status);
                errors++;
            end else begin
                t_reply e;
                e = expected_replies.pop_front();
                if (status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, status); errors++;
                end
                if (out_content !== e.content) begin
                    $error("out_content exp %h got %h", e.content, out_content); errors++;
                end
                if (out_peer !== e.peer) begin
                    $error("out_peer exp %h got %h", e.peer, out_peer); errors++;
                end
                if (out_ip !== e.ip) begin
                    $error("out_ip exp %h got %h", e.ip, out_ip); errors++;
                end
                if (out_port !== e.port) begin
                    $error("out_port exp %h got %h", e.port, out_port); errors++;
                end
                if (last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, last); errors++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted item or result
    always @(posedge clk) begin
        if (!rst_n || valid || (start && !busy)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit && !timed_out) begin
            timed_out = 1'b1;
            $display("FAIL");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_cmd_item it;
        int n;
        for (int i = 0; i < 8; i++) content_pool[i] = rand64();
        content_pool[0] = '0;
        content_pool[1] = '1;
        for (int i = 0; i < 4; i++) peer_pool[i] = rand64();
        peer_pool[0] = '0;
        peer_pool[1] = '1;

        // directed: empty list, misses, extremes, updates, removals
        pending_cmds.push_back('{cit_pkg::CMD_LIST, 64'd0, 64'd0, 32'd0, 16'd0});
        pending_cmds.push_back('{cit_pkg::CMD_SEARCH, 64'd0, 64'd0, 32'd0, 16'd0});
        pending_cmds.push_back('{cit_pkg::CMD_DEREGISTER, '1, '1, '1, '1});
        pending_cmds.push_back('{cit_pkg::CMD_REGISTER, 64'd0, 64'd0, 32'd0, 16'd0});
        pending_cmds.push_back('{cit_pkg::CMD_REGISTER, '1, '1, '1, '1});
        pending_cmds.push_back('{cit_pkg::CMD_REGISTER, '1, 64'd0, 32'h0a000001, 16'd80});
        pending_cmds.push_back('{cit_pkg::CMD_SEARCH, 64'd0, '1, 32'd0, 16'd0});
        pending_cmds.push_back('{cit_pkg::CMD_SEARCH, 64'd0, 64'd0, 32'd0, 16'd0});
        pending_cmds.push_back('{cit_pkg::CMD_LIST, 64'd0, 64'd0, 32'd0, 16'd0});
        pending_cmds.push_back('{cit_pkg::CMD_DEREGISTER, '1, 64'd0, 32'd0, 16'd0});
        pending_cmds.push_back('{cit_pkg::CMD_LIST, 64'd0, 64'd0, 32'd0, 16'd0});
        pending_cmds.push_back('{cit_pkg::CMD_SEARCH, 64'd0, 64'd0, 32'd0, 16'd0});
        pending_cmds.push_back('{cit_pkg::CMD_DEREGISTER, 64'd5, 64'd0, 32'd0, 16'd0});

        // fill the table to full, then register into full, list, remove a peer
        for (int i = 0; i < Depth + 2; i++)
            pending_cmds.push_back('{cit_pkg::CMD_REGISTER, peer_pool[i % 4], 64'h1000 + i,
                                     $urandom(), 16'($urandom())});
        pending_cmds.push_back('{cit_pkg::CMD_REGISTER, peer_pool[1], 64'h1005, 32'd7, 16'd7});
        pending_cmds.push_back('{cit_pkg::CMD_LIST, 64'd0, 64'd0, 32'd0, 16'd0});
        pending_cmds.push_back('{cit_pkg::CMD_DEREGISTER, peer_pool[2], 64'd0, 32'd0, 16'd0});
        pending_cmds.push_back('{cit_pkg::CMD_LIST, 64'd0, 64'd0, 32'd0, 16'd0});
        for (int i = 0; i < 4; i++)
            pending_cmds.push_back('{cit_pkg::CMD_DEREGISTER, peer_pool[i], 64'd0, 32'd0,
                                     16'd0});

        // random commands weighted toward register so the table grows
        n = 0;
        while (n < 232) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: it = random_cmd(cit_pkg::CMD_REGISTER);
                4, 5, 6:    it = random_cmd(cit_pkg::CMD_SEARCH);
                7:          it = random_cmd(cit_pkg::CMD_LIST);
                default:    it = random_cmd(cit_pkg::CMD_DEREGISTER);
            endcase
            pending_cmds.push_back(it);
            n++;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_cmds.size() == 0 && !start);
        wait (expected_replies.size() == 0);
        repeat (2 * Depth + 8) @(posedge clk);
        if (errors == 0 && expected_replies.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
